[rtl/mffd_pkg.sv]
// Shared types and constants of the maze flood fill engine.
`timescale 1ns / 1ps
package mffd_pkg;
   localparam int CELL_W = 10;
   localparam int DIST_W = 11;
   localparam logic [DIST_W-1:0] UNREACHED = 11'd1024;

   typedef enum logic [2:0] {
      OP_WALLS  = 3'd0,
      OP_GOAL   = 3'd1,
      OP_CLRG   = 3'd2,
      OP_CLRM   = 3'd3,
      OP_FLOOD  = 3'd4,
      OP_MOVE   = 3'd5,
      OP_NONE6  = 3'd6,
      OP_NONE7  = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      MV_FRONT = 2'd0,
      MV_RIGHT = 2'd1,
      MV_BACK  = 2'd2,
      MV_LEFT  = 2'd3
   } move_type;
endpackage

[rtl/maze_flood_fill_direction.sv]
// Maze engine: wall store, goal table, two distance maps, flood fill and move choice.
// Flood fill (algorithm_mode set): clear the spare map, seed each goal at distance zero, then for
// each expanded cell pop it, check every side (reading and checking each open neighbor), finish it.
// Throughput: one item at a time; the next one can be accepted in the cycle after the result transfer.
// Reset: synchronous; a pass over all 1024 cells then clears walls and maps, and no item is accepted.
`timescale 1ns / 1ps
module maze_flood_fill_direction
   import mffd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,          // algorithm_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,          // op[2:0], cell_x[7:3], cell_y[12:8],
                                           // wall_bits[16:13], heading[18:17]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata           // move[1:0], active_bank[2], reached[3],
                                           // cell_distance[14:4]
);
   localparam int N = 1024;

   typedef enum logic [14:0] {
      S_CLR   = 15'd1,
      S_IDLE  = 15'd2,
      S_DISP  = 15'd4,
      S_MCLR  = 15'd8,
      S_FCLR  = 15'd16,
      S_GOAL  = 15'd32,
      S_POP   = 15'd64,
      S_PRD   = 15'd128,
      S_NB    = 15'd256,
      S_NRD   = 15'd512,
      S_NCHK  = 15'd1024,
      S_MV    = 15'd2048,
      S_MVRD  = 15'd4096,
      S_FIN   = 15'd8192,
      S_FINRD = 15'd16384
   } st_type;

   logic [3:0]        wall_mem [N];
   logic [DIST_W-1:0] da_mem [N];
   logic [DIST_W-1:0] db_mem [N];
   logic [CELL_W-1:0] q_mem [N];
   logic [CELL_W-1:0] goal_ff [4];

   st_type st_ff;
   logic   mode_ff, bank_ff;
   logic [2:0]  gcnt_ff;
   logic [10:0] sweep_ff;
   logic [2:0]  op_ff;
   logic [4:0]  x_ff, y_ff;
   logic [3:0]  wb_ff;
   logic [1:0]  hd_ff;
   logic [9:0]  qh_ff, qt_ff;
   logic [10:0] qc_ff;
   logic [9:0]  cur_ff;
   logic [DIST_W-1:0] cd_ff;
   logic [3:0]  cw_ff;
   logic [2:0]  dir_ff;
   logic [1:0]  sub_ff;
   logic        reached_ff;
   logic [DIST_W-1:0] nd_ff [4];
   logic [3:0]  open_ff;
   logic        out_v_ff;
   logic [1:0]  mv_ff;
   logic [DIST_W-1:0] od_ff;

   // Memory ports: one address for walls, one for each map, one for queue.
   logic [9:0] w_addr, a_addr, b_addr, q_addr;
   logic       w_we, a_we, b_we, q_we;
   logic [3:0] w_wd;
   logic [DIST_W-1:0] a_wd, b_wd;
   logic [CELL_W-1:0] q_wd;
   logic [3:0] w_rd;
   logic [DIST_W-1:0] a_rd, b_rd;
   logic [CELL_W-1:0] q_rd;

   always_ff @(posedge clock) begin
      if (w_we) wall_mem[w_addr] <= w_wd;
      w_rd <= wall_mem[w_addr];
      if (a_we) da_mem[a_addr] <= a_wd;
      a_rd <= da_mem[a_addr];
      if (b_we) db_mem[b_addr] <= b_wd;
      b_rd <= db_mem[b_addr];
      if (q_we) q_mem[q_addr] <= q_wd;
      q_rd <= q_mem[q_addr];
   end

   wire [2:0] r_op = req_tdata[2:0];
   wire [9:0] cell_addr = {y_ff, x_ff};
   wire [DIST_W-1:0] cur_rd   = bank_ff ? b_rd : a_rd;   // current map data
   wire [DIST_W-1:0] spare_rd = bank_ff ? a_rd : b_rd;

   // Neighbor of cur_ff in direction dir_ff and whether it is inside the grid.
   logic [4:0] bx, by, nx, ny;
   logic       nin;
   always_comb begin
      bx = cur_ff[4:0];
      by = cur_ff[9:5];
      nx = bx;
      ny = by;
      nin = 1'b0;
      unique case (dir_ff[1:0])
         2'd0: begin ny = by + 5'd1; nin = (by != 5'd31); end
         2'd1: begin nx = bx + 5'd1; nin = (bx != 5'd31); end
         2'd2: begin ny = by - 5'd1; nin = (by != 5'd0); end
         default: begin nx = bx - 5'd1; nin = (bx != 5'd0); end
      endcase
   end
   wire [9:0] ncell = {ny, nx};
   wire [DIST_W-1:0] cd_inc = (cd_ff >= UNREACHED) ? UNREACHED : cd_ff + 11'd1;

   // Move choice over the four collected neighbor distances (flood mode), and first open side from the left.
   logic [DIST_W-1:0] best;
   logic [1:0] fmv, hmv;
   logic       fok, hok;
   logic [1:0] dabs;
   always_comb begin
      best = UNREACHED;
      for (int i = 0; i < 4; i++)
         if (open_ff[i] && nd_ff[i] < best) best = nd_ff[i];
      fmv = MV_BACK;
      fok = 1'b0;
      hmv = MV_BACK;
      hok = 1'b0;
      dabs = 2'd0;
      for (int k = 0; k < 3; k++) begin
         logic [1:0] rel;
         rel = (k == 0) ? MV_FRONT : (k == 1) ? MV_RIGHT : MV_LEFT;
         dabs = hd_ff + rel;
         if (!fok && open_ff[dabs] && nd_ff[dabs] == best) begin
            fok = 1'b1;
            fmv = rel;
         end
      end
      for (int k = 0; k < 4; k++) begin
         logic [1:0] rel;
         rel = 2'(k + 3);
         dabs = hd_ff + rel;
         if (!hok && open_ff[dabs]) begin
            hok = 1'b1;
            hmv = rel;
         end
      end
   end

   always_comb begin
      w_addr = cell_addr; w_we = 1'b0; w_wd = wb_ff;
      a_addr = cell_addr; a_we = 1'b0; a_wd = UNREACHED;
      b_addr = cell_addr; b_we = 1'b0; b_wd = UNREACHED;
      q_addr = qh_ff; q_we = 1'b0; q_wd = cur_ff;
      unique case (st_ff)
         S_CLR: begin
            w_addr = sweep_ff[9:0]; w_we = 1'b1; w_wd = 4'd0;
            a_addr = sweep_ff[9:0]; a_we = 1'b1;
            b_addr = sweep_ff[9:0]; b_we = 1'b1;
         end
         S_DISP: begin
            w_we = (op_ff == OP_WALLS);
         end
         S_MCLR: begin
            a_addr = sweep_ff[9:0]; a_we = 1'b1;
            b_addr = sweep_ff[9:0]; b_we = 1'b1;
         end
         S_FCLR: begin
            a_addr = sweep_ff[9:0]; a_we = bank_ff;
            b_addr = sweep_ff[9:0]; b_we = !bank_ff;
         end
         S_GOAL: begin
            a_addr = goal_ff[sweep_ff[1:0]]; b_addr = goal_ff[sweep_ff[1:0]];
            a_wd = '0; b_wd = '0;
            a_we = bank_ff; b_we = !bank_ff;
            q_addr = qt_ff; q_wd = goal_ff[sweep_ff[1:0]]; q_we = 1'b1;
         end
         S_POP: q_addr = qh_ff;
         S_PRD: begin
            w_addr = q_rd; a_addr = q_rd; b_addr = q_rd;
         end
         S_NB, S_NRD: begin
            a_addr = ncell; b_addr = ncell;
         end
         S_NCHK: begin
            a_addr = ncell; b_addr = ncell;
            a_wd = cd_inc; b_wd = cd_inc;
            q_addr = qt_ff; q_wd = ncell;
            if (spare_rd == UNREACHED) begin
               a_we = bank_ff; b_we = !bank_ff;
               q_we = (qc_ff < 11'(N));
            end
         end
         S_MV, S_MVRD: begin
            a_addr = ncell; b_addr = ncell;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR;
         mode_ff <= 1'b1;
         bank_ff <= 1'b0;
         gcnt_ff <= '0;
         sweep_ff <= '0;
         out_v_ff <= 1'b0;
         qh_ff <= '0;
         qt_ff <= '0;
         qc_ff <= '0;
      end else begin
         if (csr_we) mode_ff <= csr_wdata;
         if (out_v_ff && rsp_tready) out_v_ff <= 1'b0;
         unique case (st_ff)
            S_CLR: begin
               sweep_ff <= sweep_ff + 11'd1;
               if (sweep_ff == 11'(N - 1)) st_ff <= S_IDLE;
            end
            S_IDLE: if (req_tvalid && req_tready) begin
               op_ff <= r_op;
               x_ff <= req_tdata[7:3];
               y_ff <= req_tdata[12:8];
               wb_ff <= req_tdata[16:13];
               hd_ff <= req_tdata[18:17];
               mv_ff <= MV_FRONT;
               reached_ff <= 1'b0;
               sweep_ff <= '0;
               st_ff <= S_DISP;
            end
            S_DISP: begin
               unique case (op_ff)
                  OP_GOAL: begin
                     if (gcnt_ff < 3'd4) begin
                        goal_ff[gcnt_ff[1:0]] <= cell_addr;
                        gcnt_ff <= gcnt_ff + 3'd1;
                     end
                     st_ff <= S_FIN;
                  end
                  OP_CLRG: begin gcnt_ff <= '0; st_ff <= S_FIN; end
                  OP_CLRM: st_ff <= S_MCLR;
                  OP_FLOOD: begin
                     if (mode_ff) st_ff <= S_FCLR;
                     else begin bank_ff <= !bank_ff; st_ff <= S_FIN; end
                  end
                  OP_MOVE: begin
                     cur_ff <= cell_addr; dir_ff <= '0; sub_ff <= '0; st_ff <= S_MV;
                  end
                  default: st_ff <= S_FIN;
               endcase
            end
            S_MCLR: begin
               sweep_ff <= sweep_ff + 11'd1;
               if (sweep_ff == 11'(N - 1)) begin bank_ff <= 1'b0; st_ff <= S_FIN; end
            end
            S_FCLR: begin
               sweep_ff <= sweep_ff + 11'd1;
               qh_ff <= '0; qt_ff <= '0; qc_ff <= '0;
               if (sweep_ff == 11'(N - 1)) begin
                  sweep_ff <= '0;
                  // With no goals the empty queue still ends in a map swap.
                  st_ff <= (gcnt_ff == 3'd0) ? S_POP : S_GOAL;
               end
            end
            S_GOAL: begin
               qt_ff <= qt_ff + 10'd1;
               qc_ff <= qc_ff + 11'd1;
               sweep_ff <= sweep_ff + 11'd1;
               if (sweep_ff[2:0] + 3'd1 == gcnt_ff) st_ff <= S_POP;
            end
            S_POP: begin
               if (qc_ff == '0) begin
                  bank_ff <= !bank_ff; st_ff <= S_FIN;
               end else st_ff <= S_PRD;
            end
            S_PRD: begin
               cur_ff <= q_rd;
               qh_ff <= qh_ff + 10'd1;
               qc_ff <= qc_ff - 11'd1;
               dir_ff <= '0;
               st_ff <= S_NB;
            end
            S_NB: begin
               // Wall and own distance of the popped cell arrive now.
               if (dir_ff == 3'd0) begin cw_ff <= w_rd; cd_ff <= spare_rd; end
               if (dir_ff == 3'd4) begin
                  if (cur_ff == cell_addr) begin
                     reached_ff <= 1'b1; bank_ff <= !bank_ff; st_ff <= S_FIN;
                  end else st_ff <= S_POP;
               end else begin
                  logic [3:0] wl;
                  wl = (dir_ff == 3'd0) ? w_rd : cw_ff;
                  if (nin && !wl[dir_ff[1:0]]) st_ff <= S_NRD;
                  else dir_ff <= dir_ff + 3'd1;
               end
            end
            S_NRD: st_ff <= S_NCHK;
            S_NCHK: begin
               if (spare_rd == UNREACHED && qc_ff < 11'(N)) begin
                  qt_ff <= qt_ff + 10'd1; qc_ff <= qc_ff + 11'd1;
               end
               dir_ff <= dir_ff + 3'd1;
               st_ff <= S_NB;
            end
            S_MV: begin
               // Cell's walls read this cycle; neighbor distance per step.
               st_ff <= S_MVRD;
            end
            S_MVRD: begin
               if (dir_ff == 3'd0 && sub_ff == 2'd0) cw_ff <= w_rd;
               if (sub_ff == 2'd0) sub_ff <= 2'd1;
               else begin
                  logic [3:0] wl;
                  wl = cw_ff;
                  nd_ff[dir_ff[1:0]] <= cur_rd;
                  open_ff[dir_ff[1:0]] <= nin && !wl[dir_ff[1:0]];
                  sub_ff <= 2'd0;
                  if (dir_ff == 3'd3) st_ff <= S_FIN;
                  else begin dir_ff <= dir_ff + 3'd1; st_ff <= S_MV; end
               end
            end
            S_FIN: begin
               if (op_ff == OP_MOVE)
                  mv_ff <= (x_ff > 5'd31) ? MV_BACK : (mode_ff ? fmv : hmv);
               st_ff <= S_FINRD;
            end
            S_FINRD: begin
               // The result register is always empty here, since an item is only
               // accepted once the previous result has left.
               if (!out_v_ff) begin
                  od_ff <= cur_rd;
                  out_v_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (st_ff == S_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {1'b0, od_ff, reached_ff, bank_ff, mv_ff};
endmodule
